// ----- rtl/sas_pkg.sv -----
// Shared types and constants for the stable ascending sorter.
// No dependencies; every other file of the block but sas_checker refers to this package.
`timescale 1ns / 1ps

package sas_pkg;

	localparam int KEY_W         = 32;
	localparam int MAX_ITEMS_DEF = 16;

	typedef logic signed [KEY_W-1:0] sas_key_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} sas_state_t;

	// Per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic insert;   // place the broadcast key, shift greater keys right
		logic shift;    // move every key one cell toward the head
	} sas_cell_ctrl_t;

endpackage

// ----- rtl/sas_if.sv -----
// Valid/ready channel interfaces for the stable ascending sorter.
// Depends on sas_pkg for the key type.
`timescale 1ns / 1ps

interface sas_in_if;
	logic              valid;
	logic              ready;
	sas_pkg::sas_key_t value;
	logic              batch_end;

	modport source (output valid, output value, output batch_end, input ready);
	modport sink   (input valid, input value, input batch_end, output ready);
endinterface

interface sas_out_if;
	logic              valid;
	logic              ready;
	sas_pkg::sas_key_t sorted_value;
	logic              run_end;
	logic              overflowed;

	modport source (output valid, output sorted_value, output run_end,
		output overflowed, input ready);
	modport sink   (input valid, input sorted_value, input run_end,
		input overflowed, output ready);
endinterface

// ----- rtl/sas_cell.sv -----
// One cell of the insertion chain: holds a key and its valid bit.
// Depends on sas_pkg for the key and control types.
`timescale 1ns / 1ps

module sas_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sas_pkg::sas_cell_ctrl_t ctrl,
	input  sas_pkg::sas_key_t       new_key,
	input  logic                    left_take,
	input  sas_pkg::sas_key_t       left_key,
	input  logic                    left_valid,
	input  sas_pkg::sas_key_t       right_key,
	input  logic                    right_valid,
	output logic                    take,
	output sas_pkg::sas_key_t       key,
	output logic                    valid
);

	sas_pkg::sas_key_t key_q;
	logic              valid_q;

	// An empty cell or one holding a strictly greater key gives way; equal keys stay ahead
	assign take  = !valid_q || (key_q > new_key);
	assign key   = key_q;
	assign valid = valid_q;

	// A shift from the left carries the neighbor's valid bit along with its key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= right_valid;
		end else if (ctrl.insert) begin
			if (left_take) begin
				valid_q <= left_valid;
			end else if (take) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			key_q <= right_key;
		end else if (ctrl.insert) begin
			if (left_take) begin
				key_q <= left_key;
			end else if (take) begin
				key_q <= new_key;
			end
		end
	end

endmodule

// ----- rtl/sas_ctrl.sv -----
// Load/drain sequencer of the sorter: fill count, drop flag, handshakes.
// Depends on sas_pkg for the state enum and the cell command struct.
`timescale 1ns / 1ps

module sas_ctrl #(
	parameter int MAX_ITEMS = sas_pkg::MAX_ITEMS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_batch_end,
	input  logic                    out_ready,
	input  logic                    tail_last,
	output logic                    in_ready,
	output logic                    out_valid,
	output logic                    overflowed,
	output sas_pkg::sas_cell_ctrl_t cell_ctrl
);

	localparam int FILL_W = $clog2(MAX_ITEMS + 1);
	localparam logic [FILL_W-1:0] FULL = FILL_W'(MAX_ITEMS);

	sas_pkg::sas_state_t state_q, state_d;
	logic [FILL_W-1:0]   fill_q;
	logic                dropped_q;
	logic                in_acc;
	logic                full;

	assign full       = (fill_q == FULL);
	assign in_acc     = in_valid && in_ready;
	assign overflowed = dropped_q;

	always_comb begin
		state_d          = state_q;
		in_ready         = 1'b0;
		out_valid        = 1'b0;
		cell_ctrl.insert = 1'b0;
		cell_ctrl.shift  = 1'b0;
		unique case (state_q)
			sas_pkg::ST_LOAD: begin
				in_ready         = 1'b1;
				cell_ctrl.insert = in_valid && !full;
				if (in_valid && in_batch_end) begin
					state_d = sas_pkg::ST_DRAIN;
				end
			end
			sas_pkg::ST_DRAIN: begin
				out_valid       = 1'b1;
				cell_ctrl.shift = out_ready;
				if (out_ready && tail_last) begin
					state_d = sas_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = sas_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= sas_pkg::ST_LOAD;
			fill_q    <= '0;
			dropped_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sas_pkg::ST_DRAIN && out_ready && tail_last) begin
				fill_q    <= '0;
				dropped_q <= 1'b0;
			end else if (in_acc) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

endmodule

// ----- rtl/stable_ascending_sorter.sv -----
// Top level of the stable ascending sorter: a chain of insertion cells
// plus its load/drain sequencer. Depends on sas_pkg, sas_if, sas_cell, sas_ctrl.
`timescale 1ns / 1ps

// Usage
// in_ch carries one signed key per request; batch_end marks the last key of a batch.
// out_ch returns the batch in ascending signed order, equal keys in arrival
// order, with run_end on the final key and overflowed on every key of a batch
// that lost keys to a full buffer.
// Load: one key per cycle. Each key is compared against every cell at once
// and slides into place; greater keys move one cell toward the tail.
// Up to MAX_ITEMS keys are held; further keys of the batch are dropped.
// Drain: starts the cycle after the batch_end request and delivers one key
// per cycle from the head cell while out_ch.ready is high, the chain
// shifting toward the head on each accepted result; in_ch.ready is low
// during the drain and returns the cycle after the run_end result is taken.
// A stalled receiver holds the head cell and the whole chain unchanged.
// Reset clears every valid bit, the fill count and the drop flag; the key
// registers need no reset and the block accepts requests right after it.

module stable_ascending_sorter #(
	parameter int MAX_ITEMS = sas_pkg::MAX_ITEMS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sas_in_if.sink    in_ch,
	sas_out_if.source out_ch
);

	sas_pkg::sas_cell_ctrl_t cell_ctrl;
	sas_pkg::sas_key_t       key_w   [MAX_ITEMS];
	logic                    valid_w [MAX_ITEMS];
	logic                    take_w  [MAX_ITEMS];
	logic                    tail_last;

	// Head is the smallest key; the batch ends once the second cell is empty
	assign tail_last           = !valid_w[1];
	assign out_ch.sorted_value = key_w[0];
	assign out_ch.run_end      = tail_last;

	sas_ctrl #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_batch_end (in_ch.batch_end),
		.out_ready    (out_ch.ready),
		.tail_last    (tail_last),
		.in_ready     (in_ch.ready),
		.out_valid    (out_ch.valid),
		.overflowed   (out_ch.overflowed),
		.cell_ctrl    (cell_ctrl)
	);

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic              left_take;
		sas_pkg::sas_key_t left_key;
		logic              left_valid;
		sas_pkg::sas_key_t right_key;
		logic              right_valid;

		// Head cell has nothing to its left; tail cell has an empty neighbor
		if (i == 0) begin : g_head
			assign left_take  = 1'b0;
			assign left_key   = '0;
			assign left_valid = 1'b0;
		end else begin : g_body
			assign left_take  = take_w[i-1];
			assign left_key   = key_w[i-1];
			assign left_valid = valid_w[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign right_key   = '0;
			assign right_valid = 1'b0;
		end else begin : g_inner
			assign right_key   = key_w[i+1];
			assign right_valid = valid_w[i+1];
		end

		sas_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (cell_ctrl),
			.new_key     (in_ch.value),
			.left_take   (left_take),
			.left_key    (left_key),
			.left_valid  (left_valid),
			.right_key   (right_key),
			.right_valid (right_valid),
			.take        (take_w[i]),
			.key         (key_w[i]),
			.valid       (valid_w[i])
		);
	end

endmodule

// ----- rtl/sas_checker.sv -----
// Port-level checks of the stable ascending sorter, bound to the top level.
// Depends on stable_ascending_sorter and the sas_if interfaces.
`timescale 1ns / 1ps

module sas_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_batch_end,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] sorted_value,
	input logic        run_end
);

	// No request is taken while results are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && in_ready))
		else $error("input accepted during drain");

	// A closing request starts the drain on the next cycle
	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_batch_end) |=> out_valid)
		else $error("batch end not followed by a result");

	// A run continues without gaps until its final result
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !run_end) |=> out_valid)
		else $error("run broke off before run_end");

	// Results of one run come out in ascending signed order
	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !run_end) |=>
		($signed(sorted_value) >= $signed($past(sorted_value))))
		else $error("results not ascending");

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(sorted_value)))
		else $error("stalled result changed");

endmodule

bind stable_ascending_sorter sas_checker u_sas_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.in_batch_end (in_ch.batch_end),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.sorted_value (out_ch.sorted_value),
	.run_end      (out_ch.run_end)
);

// ----- verif/sas_batch_checker.sv -----
// Scoreboard for the stable ascending sorter: watches both channels, predicts each sorted batch.
// Depends on sas_pkg and the channel interfaces in sas_if; drives nothing on the block.
`timescale 1ns / 1ps

module sas_batch_checker #(
	parameter int MAX_ITEMS = sas_pkg::MAX_ITEMS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	sas_in_if    in_ch,
	sas_out_if   out_ch,
	output int   fail_count,
	output int   pending,
	output int   results_seen,
	output int   lost_batches
);

	typedef struct packed {
		sas_pkg::sas_key_t key;
		logic              run_end;
		logic              overflowed;
	} sorted_rec_t;

	sas_pkg::sas_key_t held_keys[$];
	logic              keys_lost  = 1'b0;
	sorted_rec_t       sorted_due[$];
	int                mismatches = 0;
	int                checked    = 0;
	int                lossy      = 0;

	// Keep the key while there is room; remember the drop otherwise.
	task automatic take_key(input sas_pkg::sas_key_t key);
		if (held_keys.size() < MAX_ITEMS)
			held_keys.push_back(key);
		else
			keys_lost = 1'b1;
	endtask

	// Stable ascending order: a key moves only past strictly greater ones.
	task automatic release_batch();
		sas_pkg::sas_key_t order[$];
		int                pos;
		foreach (held_keys[i]) begin
			pos = order.size();
			while (pos > 0 && order[pos - 1] > held_keys[i])
				pos--;
			order.insert(pos, held_keys[i]);
		end
		foreach (order[k])
			sorted_due.push_back('{order[k], k == order.size() - 1, keys_lost});
		if (keys_lost)
			lossy++;
		held_keys.delete();
		keys_lost = 1'b0;
	endtask

	task automatic check_result(input sas_pkg::sas_key_t key, input logic last,
		input logic lost);
		sorted_rec_t want;
		checked++;
		if (sorted_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected result key %0d end %0b lost %0b",
					$time, key, last, lost);
		end else begin
			want = sorted_due.pop_front();
			if (want.key !== key || want.run_end !== last || want.overflowed !== lost) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: expected key %0d end %0b lost %0b, got key %0d end %0b lost %0b",
						$time, want.key, want.run_end, want.overflowed, key, last, lost);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				take_key(in_ch.value);
				if (in_ch.batch_end)
					release_batch();
			end
			if (out_ch.valid && out_ch.ready)
				check_result(out_ch.sorted_value, out_ch.run_end, out_ch.overflowed);
		end
		fail_count   <= mismatches;
		pending      <= sorted_due.size();
		results_seen <= checked;
		lost_batches <= lossy;
	end

endmodule

// ----- verif/tb.sv -----
// Testbench top for the stable ascending sorter: clock, reset, key requests and result pacing.
// Depends on sas_pkg, sas_if, the sorter RTL and sas_batch_checker.
`timescale 1ns / 1ps

module tb;

	localparam int     DEPTH         = sas_pkg::MAX_ITEMS_DEF;
	localparam int     ITEM_GOAL     = 480;
	// from this many keys on, neither side idles any more
	localparam int     CALM_FROM     = 420;
	// a full load plus a full drain, with a little margin
	localparam int     SETTLE_CYCLES = 2 * DEPTH + 4;
	// many times the slowest legal run
	localparam longint LIMIT_NS      = 2_000_000;

	// How the keys of one batch are drawn
	typedef enum int {
		KEYS_WIDE,     // any 32-bit pattern
		KEYS_CLOSE,    // a narrow band around zero, so equal keys are common
		KEYS_EXTREME   // mostly the signed limits, their neighbors, zero and minus one
	} key_mix_t;

	logic clk;
	logic arst_n;

	sas_in_if  in_ch ();
	sas_out_if out_ch ();

	int fail_count;
	int pending;
	int results_seen;
	int lost_batches;

	int items_sent;
	int gap_odds;     // chance, in eighths, of a sender gap before a request
	bit calm;         // end of run: result side stops stalling

	stable_ascending_sorter #(.MAX_ITEMS(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	sas_batch_checker #(.MAX_ITEMS(DEPTH)) order_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.out_ch       (out_ch),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.lost_batches (lost_batches)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs or loses a result.
	initial begin
		#(LIMIT_NS);
		$display("tb: errors");
		$finish;
	end

	function automatic sas_pkg::sas_key_t pick_key(input key_mix_t mix);
		case (mix)
			KEYS_CLOSE: return sas_pkg::sas_key_t'(int'($urandom_range(0, 8)) - 4);
			KEYS_EXTREME: begin
				case ($urandom_range(0, 6))
					0: return 32'sh8000_0000;
					1: return 32'sh8000_0001;
					2: return 32'sh7FFF_FFFF;
					3: return 32'sh7FFF_FFFE;
					4: return '0;
					5: return '1;
					default: return $urandom;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Present one key and hold it until the block takes the request.
	// Valid stays high straight into the next request unless a gap is drawn,
	// so it is never dropped and raised in the same step.
	task automatic send_key(input sas_pkg::sas_key_t key, input logic last);
		if (items_sent < CALM_FROM && gap_odds != 0 && $urandom_range(0, 7) < gap_odds) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.value     <= key;
		in_ch.batch_end <= last;
		@(posedge clk);
		// ready is low during a drain, so this also waits out a whole batch
		while (!in_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Result side: stall in bursts, with ready stretches between.
	initial begin : result_pacing
		int stall_left;
		int ready_left;
		out_ch.ready <= 1'b0;
		stall_left = 0;
		ready_left = 0;
		forever begin
			@(posedge clk);
			if (calm) begin
				out_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else if (ready_left > 0) begin
				out_ch.ready <= 1'b1;
				ready_left--;
			end else if ($urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 18);
			end else begin
				out_ch.ready <= 1'b1;
				ready_left = $urandom_range(0, 40);
			end
		end
	end

	initial begin : stimulus
		int       n;
		key_mix_t mix;

		// hold every input at a known value from time zero
		arst_n          <= 1'b0;
		in_ch.valid     <= 1'b0;
		in_ch.value     <= '0;
		in_ch.batch_end <= 1'b0;
		calm            <= 1'b0;
		items_sent = 0;
		gap_odds   = 3;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-key batch at the most negative value
		send_key(32'sh8000_0000, 1'b1);

		// Both signed limits, zero and minus one, out of order
		send_key(32'sh7FFF_FFFF, 1'b0);
		send_key(32'sh8000_0000, 1'b0);
		send_key('0, 1'b0);
		send_key('1, 1'b1);

		// Equal keys only
		send_key(32'sd7, 1'b0);
		send_key(32'sd7, 1'b1);

		// Overfill the buffer by two; the batch_end key itself is dropped,
		// yet the held keys must still drain with the overflow flag set
		for (int i = 0; i < DEPTH + 2; i++)
			send_key(sas_pkg::sas_key_t'(((DEPTH - i) % 6) * 1000 - 2500), i == DEPTH + 1);

		// Random batches: mostly within capacity, one in ten overfilled
		while (items_sent < ITEM_GOAL) begin
			if (items_sent >= CALM_FROM)
				calm <= 1'b1;
			if ($urandom_range(0, 9) == 0)
				n = $urandom_range(DEPTH + 1, DEPTH + 6);
			else
				n = $urandom_range(1, DEPTH);
			mix      = key_mix_t'($urandom_range(0, 2));
			gap_odds = $urandom_range(0, 3);
			for (int i = 0; i < n; i++)
				send_key(pick_key(mix), i == n - 1);
		end
		in_ch.valid <= 1'b0;

		// Let the checker see the final request, then drain what is owed.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		// catch any stray result after the last expected one
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (pending != 0)
			$display("%0d sorted results never arrived", pending);
		$display("summary: %0d keys sent, %0d sorted results checked, %0d batches overflowed",
			items_sent, results_seen, lost_batches);
		if (fail_count == 0 && pending == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ----- stable_ascending_sorter.f -----
rtl/sas_pkg.sv
rtl/sas_if.sv
rtl/sas_cell.sv
rtl/sas_ctrl.sv
rtl/stable_ascending_sorter.sv
rtl/sas_checker.sv
verif/sas_batch_checker.sv
verif/tb.sv
